@@ hdl/mcg_pkg.sv @@
package mcg_pkg;

    // defaults for the top level parameters
    localparam int unsigned SINE_DEPTH_DEF = 1024;
    localparam int unsigned POS_WIDTH_DEF  = 24;

    // largest bar length the counter honors
    localparam int unsigned MAX_BEATS = 8;

    // register field widths
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned LEN_W       = 24;
    localparam int unsigned BPB_W       = 4;
    localparam int unsigned INC_W       = 32;
    localparam int unsigned SLOPE_W     = 16;
    localparam int unsigned BEAT_W      = 3;
    localparam int unsigned SAMPLE_W    = 16;
    localparam int unsigned MAG_W       = 15;
    localparam int unsigned ENV_W       = 16;
    localparam int unsigned SCALED_W    = MAG_W + ENV_W - 17;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BEAT_LENGTH      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BEATS_PER_BAR    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCENT_INCREMENT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NORMAL_INCREMENT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_SLOPE      = 3'd4;

    // register reset values
    localparam logic [LEN_W-1:0]   RST_BEAT_LENGTH      = 24'd22050;
    localparam logic [BPB_W-1:0]   RST_BEATS_PER_BAR    = 4'd4;
    localparam logic [INC_W-1:0]   RST_ACCENT_INCREMENT = 32'd97391549;
    localparam logic [INC_W-1:0]   RST_NORMAL_INCREMENT = 32'd48695775;
    localparam logic [SLOPE_W-1:0] RST_DECAY_SLOPE      = 16'd149;

    // envelope full scale, Q0.16
    localparam logic [ENV_W-1:0] ENV_FULL = 16'hFFFF;

    // quarter-wave sine polynomial coefficients, Q2.30
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] SIN_C1  = 64'd1686629713;
    localparam logic [63:0] SIN_C3  = 64'd693598668;
    localparam logic [63:0] SIN_C5  = 64'd85569306;
    localparam logic [63:0] SIN_C7  = 64'd5026995;
    localparam logic [63:0] SIN_C9  = 64'd172272;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENV,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic env_load;
        logic mul_load;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // table entry k of a depth-entry sine table: {negative, magnitude Q0.15}
    function automatic logic [MAG_W:0] sine_entry(input int unsigned k,
                                                   input int unsigned depth);
        logic [63:0] frac;
        logic [63:0] rem;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] t;
        logic [63:0] r;
        logic [1:0]  quad;
        frac = (64'(k) << 32) / 64'(depth);
        quad = frac[31:30];
        rem  = frac & (Q30_ONE - 64'd1);
        u    = quad[0] ? (Q30_ONE - rem) : rem;
        u2   = (u * u) >> 30;
        t    = SIN_C9;
        t    = SIN_C7 - ((u2 * t) >> 30);
        t    = SIN_C5 - ((u2 * t) >> 30);
        t    = SIN_C3 - ((u2 * t) >> 30);
        t    = SIN_C1 - ((u2 * t) >> 30);
        r    = (u * t) >> 30;
        r    = (r + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return {quad[1], r[MAG_W-1:0]};
    endfunction

endpackage

@@ hdl/mcg_ctrl.sv @@
module mcg_ctrl
    import mcg_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_tick,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_tick) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_ENV;
                end
            end
            ST_ENV: begin
                cmd.env_load = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a sample tick runs the full envelope and scale sequence
    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_tick) |=> (state_reg == ST_ENV))
        else $error("tick transfer did not start the sequence");

    a_env_then_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ENV) |=> (state_reg == ST_MUL))
        else $error("envelope step not followed by multiply");

    // result is loaded only at the end of a sequence
    a_load_after_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> ($past(state_reg) == ST_MUL || $past(state_reg) == ST_OUT))
        else $error("result loaded outside the sequence");

endmodule

@@ hdl/mcg_datapath.sv @@
module mcg_datapath
    import mcg_pkg::*;
#(
    parameter int unsigned SINE_DEPTH = SINE_DEPTH_DEF,
    parameter int unsigned POS_WIDTH  = POS_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    input  dp_cmd_t                     cmd,
    output dp_status_t                  status,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]  m_click_sample,
    output logic                        m_accent,
    output logic [BEAT_W-1:0]           m_beat_index
);

    localparam int unsigned IDX_W  = $clog2(SINE_DEPTH);
    localparam int unsigned CMP_W  = (POS_WIDTH > LEN_W) ? POS_WIDTH : LEN_W;
    localparam int unsigned DROP_W = POS_WIDTH + SLOPE_W;
    localparam int unsigned BAR_W  = BPB_W + 1;

    typedef logic [MAG_W:0] rom_t [SINE_DEPTH];

    function automatic rom_t build_rom();
        rom_t rom;
        for (int unsigned k = 0; k < SINE_DEPTH; k++) begin
            rom[k] = sine_entry(k, SINE_DEPTH);
        end
        return rom;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    // configuration registers
    logic [LEN_W-1:0]   beat_length_reg;
    logic [BPB_W-1:0]   beats_per_bar_reg;
    logic [INC_W-1:0]   accent_increment_reg;
    logic [INC_W-1:0]   normal_increment_reg;
    logic [SLOPE_W-1:0] decay_slope_reg;

    // beat and tone state
    logic [POS_WIDTH-1:0] beat_position_reg;
    logic [BEAT_W-1:0]    beat_counter_reg;
    logic [INC_W-1:0]     accent_phase_reg;
    logic [INC_W-1:0]     normal_phase_reg;

    // sample pipeline
    logic [MAG_W:0]      rom_q_reg;
    logic [DROP_W-1:0]   drop_reg;
    logic                accent_reg;
    logic [BEAT_W-1:0]   beat_idx_reg;
    logic [ENV_W-1:0]    env_reg;
    logic [SCALED_W-1:0] scaled_reg;

    // result register
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       m_accent_reg;
    logic [BEAT_W-1:0]          m_beat_index_reg;

    logic                 accented;
    logic [INC_W-1:0]     phase_sel;
    logic [INC_W+IDX_W-1:0] idx_product;
    logic [IDX_W-1:0]     rom_addr;
    logic [POS_WIDTH-1:0] pos_inc;
    logic [LEN_W-1:0]     len_eff;
    logic                 beat_wrap;
    logic [BEAT_W-1:0]    cnt_step;
    logic [BAR_W-1:0]     bar_len;
    logic [POS_WIDTH-1:0] beat_position_next;
    logic [BEAT_W-1:0]    beat_counter_next;
    logic [ENV_W-1:0]     env_next;
    logic [MAG_W+ENV_W-1:0] product;
    logic [SAMPLE_W-1:0]  scaled_ext;
    logic [SAMPLE_W-1:0]  sample_next;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_length_reg      <= RST_BEAT_LENGTH;
            beats_per_bar_reg    <= RST_BEATS_PER_BAR;
            accent_increment_reg <= RST_ACCENT_INCREMENT;
            normal_increment_reg <= RST_NORMAL_INCREMENT;
            decay_slope_reg      <= RST_DECAY_SLOPE;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BEAT_LENGTH:      beat_length_reg      <= cfg_wdata[LEN_W-1:0];
                REG_BEATS_PER_BAR:    beats_per_bar_reg    <= cfg_wdata[BPB_W-1:0];
                REG_ACCENT_INCREMENT: accent_increment_reg <= cfg_wdata[INC_W-1:0];
                REG_NORMAL_INCREMENT: normal_increment_reg <= cfg_wdata[INC_W-1:0];
                REG_DECAY_SLOPE:      decay_slope_reg      <= cfg_wdata[SLOPE_W-1:0];
                default: ;
            endcase
        end
    end

    // tone select and table address, phase times depth over 2^32
    assign accented    = (beat_counter_reg == '0);
    assign phase_sel   = accented ? accent_phase_reg : normal_phase_reg;
    assign idx_product = (INC_W+IDX_W)'(phase_sel) * (INC_W+IDX_W)'(SINE_DEPTH);
    assign rom_addr    = idx_product[INC_W +: IDX_W];

    // beat position and bar counter advance
    always_comb begin
        pos_inc   = beat_position_reg + POS_WIDTH'(1);
        len_eff   = (beat_length_reg == '0) ? LEN_W'(1) : beat_length_reg;
        beat_wrap = (pos_inc == '0) || (CMP_W'(pos_inc) >= CMP_W'(len_eff));
        beat_position_next = beat_wrap ? '0 : pos_inc;
        cnt_step  = beat_wrap ? (beat_counter_reg + BEAT_W'(1)) : beat_counter_reg;
        if (beats_per_bar_reg == '0) begin
            bar_len = BAR_W'(1);
        end else if (BAR_W'(beats_per_bar_reg) > BAR_W'(MAX_BEATS)) begin
            bar_len = BAR_W'(MAX_BEATS);
        end else begin
            bar_len = BAR_W'(beats_per_bar_reg);
        end
        beat_counter_next = (BAR_W'(cnt_step) >= bar_len) ? '0 : cnt_step;
    end

    // state update and first stage: table read and envelope drop product
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_position_reg <= '0;
            beat_counter_reg  <= '0;
            accent_phase_reg  <= '0;
            normal_phase_reg  <= '0;
        end else if (cmd.capture) begin
            beat_position_reg <= beat_position_next;
            beat_counter_reg  <= beat_counter_next;
            accent_phase_reg  <= accent_phase_reg + accent_increment_reg;
            normal_phase_reg  <= normal_phase_reg + normal_increment_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            rom_q_reg    <= SINE_ROM[rom_addr];
            drop_reg     <= DROP_W'(beat_position_reg) * DROP_W'(decay_slope_reg);
            accent_reg   <= accented;
            beat_idx_reg <= beat_counter_reg;
        end
    end

    // envelope, held at zero once the drop reaches full scale
    assign env_next = (drop_reg >= DROP_W'(ENV_FULL)) ? '0
                                                       : (ENV_FULL - drop_reg[ENV_W-1:0]);

    always_ff @(posedge aclk) begin
        if (cmd.env_load) begin
            env_reg <= env_next;
        end
    end

    // envelope times magnitude, gain of one half folded into the shift
    assign product = (MAG_W+ENV_W)'(rom_q_reg[MAG_W-1:0]) * (MAG_W+ENV_W)'(env_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            scaled_reg <= product[MAG_W+ENV_W-1 -: SCALED_W];
        end
    end

    // sign restore
    assign scaled_ext  = SAMPLE_W'(scaled_reg);
    assign sample_next = rom_q_reg[MAG_W] ? (SAMPLE_W'(0) - scaled_ext) : scaled_ext;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            sample_reg       <= signed'(sample_next);
            m_accent_reg     <= accent_reg;
            m_beat_index_reg <= beat_idx_reg;
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_click_sample  = sample_reg;
    assign m_accent        = m_accent_reg;
    assign m_beat_index    = m_beat_index_reg;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before transfer");

    // accent flag marks exactly beat zero
    a_accent_beat0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_accent_reg == (m_beat_index_reg == '0)))
        else $error("accent flag does not match beat index");

    // state moves only on a sample tick
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(cmd.capture) && $past(aresetn) |-> $stable(accent_phase_reg))
        else $error("phase changed without a tick");

endmodule

@@ hdl/metronome_click_generator_top.sv @@
// channel  | handshake          | payload
// ---------+--------------------+---------------------------------------------
// input    | s_valid / s_ready  | s_tick
// result   | m_valid / m_ready  | m_click_sample, m_accent, m_beat_index
// config   | cfg_wr_en          | cfg_index, cfg_wdata
//
// a tick transfer runs table read and drop product, envelope,
// scale multiply, result load; the controller sequence sets these steps
// a transfer with tick low is taken and gives no result
// the next input is taken while the previous result waits in the output register
// a stalled result register holds the sequence in its last step until m_ready
// reset (aresetn low, synchronous) clears beat state, phases and loads defaults
module metronome_click_generator_top
    import mcg_pkg::*;
#(
    parameter int unsigned SINE_DEPTH = SINE_DEPTH_DEF,
    parameter int unsigned POS_WIDTH  = POS_WIDTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_tick,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]  m_click_sample,
    output logic                        m_accent,
    output logic [BEAT_W-1:0]           m_beat_index
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequence controller
    mcg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_tick  (s_tick),
        .status  (status),
        .cmd     (cmd)
    );

    // beat state, tone table and sample datapath
    mcg_datapath #(
        .SINE_DEPTH (SINE_DEPTH),
        .POS_WIDTH  (POS_WIDTH)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_click_sample (m_click_sample),
        .m_accent       (m_accent),
        .m_beat_index   (m_beat_index)
    );

endmodule
